// ===== hdl/bpa_pkg.sv =====
package bpa_pkg;

	// Field widths of one request and one result
	localparam int KIND_W = 2;
	localparam int SIZE_W = 27;
	localparam int ADDR_W = 26;
	localparam int FREE_W = 27;
	localparam int STAT_W = 2;

	// Map word geometry
	localparam int WORD_BITS = 64;
	localparam int WSEL_W    = 6;
	localparam int WCNT_W    = 7;

	// Divider lanes: page count of the size, first page of the address
	localparam int DIV_LANES = 2;

	// Request kinds
	localparam logic [KIND_W-1:0] REQ_ALLOC  = 2'd0;
	localparam logic [KIND_W-1:0] REQ_FREE   = 2'd1;
	localparam logic [KIND_W-1:0] REQ_QUERY  = 2'd2;
	localparam logic [KIND_W-1:0] REQ_REINIT = 2'd3;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOMEM   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_INVALID = 2'd2;

	typedef logic [WORD_BITS-1:0] word_t;

	typedef struct packed {
		logic [KIND_W-1:0] req_type;
		logic [SIZE_W-1:0] size_bytes;
		logic [ADDR_W-1:0] base_address;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [ADDR_W-1:0] result_address;
		logic [FREE_W-1:0] free_bytes;
	} rsp_t;

	// What the word walk does to each map word it visits
	typedef enum logic [2:0] {
		WM_INIT,
		WM_SCAN,
		WM_SET,
		WM_CLR,
		WM_COUNT
	} walk_mode_t;

	typedef enum logic [3:0] {
		S_BOOT_BEGIN,
		S_BOOT_WALK,
		S_IDLE,
		S_DIV,
		S_BEGIN,
		S_WALK,
		S_MARK_BEGIN,
		S_MARK_WALK,
		S_RESULT
	} ctrl_state_t;

	typedef struct packed {
		logic       capture;
		logic       begin_walk;
		walk_mode_t mode;
		logic       run;
		logic       result;
	} dp_cmd_t;

	typedef struct packed {
		logic              div_done;
		logic              walk_done;
		logic              hit;
		logic              need_zero;
		logic              range_empty;
		logic [KIND_W-1:0] kind;
	} dp_stat_t;

	// Index of the lowest set bit (0 when none)
	function automatic logic [WSEL_W-1:0] lsb_index(input word_t v);
		logic [WSEL_W-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = WSEL_W'(i);
			end
		end
		return idx;
	endfunction

	// Index of the highest set bit (0 when none)
	function automatic logic [WSEL_W-1:0] msb_index(input word_t v);
		logic [WSEL_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (v[i]) begin
				idx = WSEL_W'(i);
			end
		end
		return idx;
	endfunction

	function automatic logic [WCNT_W-1:0] popcount(input word_t v);
		logic [WCNT_W-1:0] cnt;
		cnt = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			cnt = cnt + WCNT_W'(v[i]);
		end
		return cnt;
	endfunction

endpackage

// ===== hdl/bitmap_page_allocator.sv =====
// First-fit page allocator over a used-bit map held as 64-bit words, one word per cycle.
// Allocate: divide, scan the map first-fit, then mark the words of the run found.
// Free: divide, then clear the words of the range; query and reinit walk the whole map.
// One transaction at a time; the map word walk through the single read port sets the rate.
// After reset the map is rewritten word by word with busy high.
// Each result shows on done for one cycle; the receiver cannot stall.
module bitmap_page_allocator
	import bpa_pkg::*;
#(
	parameter int PAGE_COUNT = 16384,
	parameter int PAGE_BYTES = 4096
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	bpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.start_kind(req.req_type),
		.stat      (stat),
		.busy      (busy),
		.cmd       (cmd)
	);

	bpa_dp #(
		.PAGE_COUNT(PAGE_COUNT),
		.PAGE_BYTES(PAGE_BYTES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp_vld(done),
		.rsp    (rsp)
	);

endmodule

// ===== hdl/bpa_div.sv =====
module bpa_div
	import bpa_pkg::*;
#(
	parameter int DIVD_W  = 28,
	parameter int DIVISOR = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [DIV_LANES-1:0][DIVD_W-1:0]     dividend,
	output logic                                 done,
	output logic [DIV_LANES-1:0][DIVD_W-1:0]     quotient
);

	// Scaled reciprocal, exact for every dividend below 2**DIVD_W
	localparam int SHIFT = DIVD_W + $clog2(DIVISOR);
	localparam longint unsigned RECIP = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;
	localparam int RCP_W = DIVD_W + 1;
	localparam int PRD_W = DIVD_W + RCP_W;
	localparam logic [RCP_W-1:0] RCP = RCP_W'(RECIP);

	logic                                 step_q;
	logic                                 done_q;
	logic [DIV_LANES-1:0][DIVD_W-1:0]     dvd_q;
	logic [DIV_LANES-1:0][DIVD_W-1:0]     quot_q;
	logic [DIV_LANES-1:0][DIVD_W-1:0]     quot_nx;

	// Quotient per lane: multiply by the reciprocal and keep the top bits
	always_comb begin
		logic [PRD_W-1:0] prod;
		for (int l = 0; l < DIV_LANES; l++) begin
			prod       = PRD_W'(dvd_q[l]) * PRD_W'(RCP);
			quot_nx[l] = DIVD_W'(prod >> SHIFT);
		end
	end

	// Sequence: capture the dividends, then register the quotients
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			step_q <= start;
			if (start) begin
				done_q <= 1'b0;
			end else if (step_q) begin
				done_q <= 1'b1;
			end
		end
	end

	// Dividend and quotient registers
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
		end
		if (step_q) begin
			quot_q <= quot_nx;
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

// ===== hdl/bpa_dp.sv =====
module bpa_dp
	import bpa_pkg::*;
#(
	parameter int PAGE_COUNT = 16384,
	parameter int PAGE_BYTES = 4096
) (
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     req,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat,
	output logic     rsp_vld,
	output rsp_t     rsp
);

	localparam int MAP_WORDS = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int PCW       = $clog2(PAGE_COUNT + 1);
	localparam int DIVD_W    = SIZE_W + 1;
	localparam int FLOG      = $clog2(PAGE_BYTES + 1) - 1;
	localparam int QW        = DIVD_W - FLOG;
	localparam int CW0       = (QW > PCW) ? QW : PCW;
	localparam int CW        = ((CW0 > WIDX_W + WSEL_W) ? CW0 : WIDX_W + WSEL_W) + 2;
	localparam int MULW      = PCW + FLOG + 1;
	localparam int LAST_BITS = PAGE_COUNT - WORD_BITS * (MAP_WORDS - 1);
	localparam word_t PAD_MASK = ~({WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS));
	localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(MAP_WORDS - 1);

	// Page used map, one bit per page
	word_t map_mem [MAP_WORDS];

	logic [KIND_W-1:0] kind_q;
	walk_mode_t        mode_q;
	logic [WIDX_W-1:0] rd_ptr_q;
	logic [WIDX_W-1:0] lo_word_q;
	logic [WIDX_W-1:0] hi_word_q;
	logic [WSEL_W-1:0] lo_off_q;
	logic [WSEL_W-1:0] hi_off_q;
	logic              issue_q;
	logic              vld_s1;
	logic [WIDX_W-1:0] idx_s1;
	word_t             rdata_s1;
	logic [PCW-1:0]    carry_q;
	logic [PCW-1:0]    count_q;
	logic [PCW-1:0]    start_q;
	logic              hit_q;
	logic              rsp_vld_q;
	rsp_t              rsp_q;

	logic [DIV_LANES-1:0][DIVD_W-1:0] dvd;
	logic [DIV_LANES-1:0][DIVD_W-1:0] quot;
	logic                             div_done;

	logic [QW-1:0]     need;
	logic [QW-1:0]     first;
	logic [CW-1:0]     end_w;
	logic [CW-1:0]     hi_clamp;
	logic              range_empty;
	logic [CW-1:0]     rng_lo;
	logic [CW-1:0]     rng_hi;

	logic              rd_en;
	logic              wr_en;
	logic              proc;
	word_t             pad_w;
	word_t             scan_used;
	word_t             free_w;
	word_t             pk [WSEL_W+1];
	word_t             acc;
	logic [WCNT_W-1:0] nlen;
	logic              need_small;
	logic              win_hit;
	logic              cross_hit;
	logic [WCNT_W-1:0] tz;
	logic [WCNT_W-1:0] lz;
	logic [CW-1:0]     base;
	logic [CW-1:0]     hit_start;
	logic              hit_now;
	logic              walk_last;
	word_t             lo_m;
	word_t             hi_m;
	word_t             wdata;
	rsp_t              rsp_nx;

	// Page counts by division with a constant page size
	assign dvd[0] = DIVD_W'(req.size_bytes) + DIVD_W'(PAGE_BYTES - 1);
	assign dvd[1] = DIVD_W'(req.base_address);

	bpa_div #(
		.DIVD_W (DIVD_W),
		.DIVISOR(PAGE_BYTES)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.capture),
		.dividend(dvd),
		.done    (div_done),
		.quotient(quot)
	);

	assign need  = QW'(quot[0]);
	assign first = QW'(quot[1]);

	// Free range, clipped at the end of the map
	always_comb begin
		end_w       = CW'(first) + CW'(need);
		hi_clamp    = (end_w > CW'(PAGE_COUNT)) ? CW'(PAGE_COUNT) : end_w;
		range_empty = (CW'(first) >= hi_clamp);
	end

	// Page range of the walk about to begin
	always_comb begin
		case (cmd.mode)
			WM_SET: begin
				rng_lo = CW'(start_q);
				rng_hi = CW'(start_q) + CW'(need);
			end
			WM_CLR: begin
				rng_lo = CW'(first);
				rng_hi = hi_clamp;
			end
			default: begin
				rng_lo = '0;
				rng_hi = CW'(PAGE_COUNT);
			end
		endcase
	end

	assign rd_en = cmd.run && issue_q;
	assign proc  = cmd.run && vld_s1;

	// Map word as seen by the walk: tail pad always used, page 0 held back on a scan
	always_comb begin
		pad_w     = rdata_s1 | ((idx_s1 == LAST_WORD) ? PAD_MASK : '0);
		scan_used = pad_w | ((idx_s1 == '0) ? word_t'(1) : '0);
		free_w    = ~scan_used;
	end

	// Runs of free pages that fit inside one word, for short requests
	always_comb begin
		nlen  = WCNT_W'(need);
		pk[0] = free_w;
		for (int k = 1; k <= WSEL_W; k++) begin
			pk[k] = pk[k-1] & (pk[k-1] << (1 << (k - 1)));
		end
		acc = '1;
		for (int j = 0; j <= WSEL_W; j++) begin
			if (nlen[j]) begin
				acc = acc & (pk[j] << (nlen & WCNT_W'((1 << j) - 1)));
			end
		end
	end

	// First-fit decision for the current word
	always_comb begin
		need_small = (CW'(need) <= CW'(WORD_BITS));
		win_hit    = need_small && (acc != '0);
		tz         = (scan_used == '0) ? WCNT_W'(WORD_BITS) : WCNT_W'(lsb_index(scan_used));
		lz         = (scan_used == '0) ? WCNT_W'(WORD_BITS)
			: WCNT_W'(WORD_BITS - 1) - WCNT_W'(msb_index(scan_used));
		base       = CW'(idx_s1) << WSEL_W;
		cross_hit  = (CW'(carry_q) + CW'(tz)) >= CW'(need);
		hit_start  = cross_hit ? (base - CW'(carry_q))
			: (base + CW'(lsb_index(acc)) + CW'(1) - CW'(nlen));
		hit_now    = proc && (mode_q == WM_SCAN) && (cross_hit || win_hit);
		walk_last  = proc && (idx_s1 == hi_word_q);
	end

	// Word update for init, set and clear
	always_comb begin
		lo_m = (idx_s1 == lo_word_q) ? (word_t'('1) << lo_off_q) : '1;
		hi_m = (idx_s1 == hi_word_q)
			? (word_t'('1) >> (WSEL_W'(WORD_BITS - 1) - hi_off_q)) : '1;
		case (mode_q)
			WM_INIT: wdata = (idx_s1 == '0) ? word_t'(1) : '0;
			WM_SET:  wdata = rdata_s1 | (lo_m & hi_m);
			WM_CLR:  wdata = rdata_s1 & ~(lo_m & hi_m);
			default: wdata = rdata_s1;
		endcase
		wr_en = proc && (mode_q == WM_INIT || mode_q == WM_SET || mode_q == WM_CLR);
	end

	// Map memory: one read and one write port, registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= map_mem[rd_ptr_q];
		end
		if (wr_en) begin
			map_mem[idx_s1] <= wdata;
		end
	end

	// Result of the finished transaction
	always_comb begin
		rsp_nx = '0;
		case (kind_q)
			REQ_ALLOC: begin
				if (need == '0) begin
					rsp_nx.status = STAT_INVALID;
				end else if (!hit_q) begin
					rsp_nx.status = STAT_NOMEM;
				end else begin
					rsp_nx.status         = STAT_OK;
					rsp_nx.result_address = ADDR_W'(MULW'(start_q) * MULW'(PAGE_BYTES));
				end
			end
			REQ_QUERY: begin
				rsp_nx.status     = STAT_OK;
				rsp_nx.free_bytes = FREE_W'(MULW'(count_q) * MULW'(PAGE_BYTES));
			end
			default: begin
				rsp_nx.status = STAT_OK;
			end
		endcase
	end

	// Walk control and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q   <= 1'b0;
			vld_s1    <= 1'b0;
			hit_q     <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			rsp_vld_q <= cmd.result;
			if (cmd.capture) begin
				hit_q <= 1'b0;
			end else if (hit_now) begin
				hit_q <= 1'b1;
			end
			if (cmd.begin_walk) begin
				issue_q <= 1'b1;
				vld_s1  <= 1'b0;
			end else begin
				vld_s1 <= rd_en;
				if (rd_en) begin
					issue_q <= (rd_ptr_q != hi_word_q);
				end
			end
		end
	end

	// Walk datapath registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= req.req_type;
		end
		if (cmd.begin_walk) begin
			mode_q    <= cmd.mode;
			lo_word_q <= WIDX_W'(rng_lo >> WSEL_W);
			hi_word_q <= WIDX_W'((rng_hi - CW'(1)) >> WSEL_W);
			lo_off_q  <= WSEL_W'(rng_lo);
			hi_off_q  <= WSEL_W'(rng_hi - CW'(1));
			rd_ptr_q  <= WIDX_W'(rng_lo >> WSEL_W);
			carry_q   <= '0;
			count_q   <= '0;
		end else begin
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + WIDX_W'(1);
			end
			if (rd_en || proc) begin
				idx_s1 <= rd_ptr_q;
			end
			if (proc && mode_q == WM_COUNT) begin
				count_q <= count_q + PCW'(popcount(~pad_w));
			end
			if (hit_now) begin
				start_q <= PCW'(hit_start);
			end else if (proc && mode_q == WM_SCAN) begin
				carry_q <= (scan_used == '0) ? PCW'(CW'(carry_q) + CW'(WORD_BITS)) : PCW'(lz);
			end
		end
		if (cmd.result) begin
			rsp_q <= rsp_nx;
		end
	end

	assign stat.div_done    = div_done;
	assign stat.walk_done   = walk_last || hit_now;
	assign stat.hit         = hit_now;
	assign stat.need_zero   = (need == '0);
	assign stat.range_empty = range_empty;
	assign stat.kind        = kind_q;

	assign rsp_vld = rsp_vld_q;
	assign rsp     = rsp_q;

endmodule

// ===== hdl/bpa_ctrl.sv =====
module bpa_ctrl
	import bpa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [KIND_W-1:0] start_kind,
	input  dp_stat_t          stat,
	output logic              busy,
	output dp_cmd_t           cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_BOOT_BEGIN;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_BOOT_BEGIN: state_nx = S_BOOT_WALK;
			S_BOOT_WALK: begin
				if (stat.walk_done) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					if (start_kind inside {REQ_ALLOC, REQ_FREE}) begin
						state_nx = S_DIV;
					end else begin
						state_nx = S_BEGIN;
					end
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					if (stat.kind == REQ_ALLOC) begin
						state_nx = stat.need_zero ? S_RESULT : S_BEGIN;
					end else begin
						state_nx = stat.range_empty ? S_RESULT : S_BEGIN;
					end
				end
			end
			S_BEGIN: state_nx = S_WALK;
			S_WALK: begin
				if (stat.walk_done) begin
					if (stat.kind == REQ_ALLOC && stat.hit) begin
						state_nx = S_MARK_BEGIN;
					end else begin
						state_nx = S_RESULT;
					end
				end
			end
			S_MARK_BEGIN: state_nx = S_MARK_WALK;
			S_MARK_WALK: begin
				if (stat.walk_done) begin
					state_nx = S_RESULT;
				end
			end
			S_RESULT: state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd            = '0;
		cmd.mode       = WM_INIT;
		busy           = (state_q != S_IDLE);
		cmd.capture    = (state_q == S_IDLE) && start;
		cmd.begin_walk = (state_q == S_BOOT_BEGIN) || (state_q == S_BEGIN)
			|| (state_q == S_MARK_BEGIN);
		cmd.run        = (state_q == S_BOOT_WALK) || (state_q == S_WALK)
			|| (state_q == S_MARK_WALK);
		cmd.result     = (state_q == S_RESULT);
		case (state_q)
			S_BEGIN: begin
				case (stat.kind)
					REQ_ALLOC: cmd.mode = WM_SCAN;
					REQ_FREE:  cmd.mode = WM_CLR;
					REQ_QUERY: cmd.mode = WM_COUNT;
					default:   cmd.mode = WM_INIT;
				endcase
			end
			S_MARK_BEGIN: cmd.mode = WM_SET;
			default:      cmd.mode = WM_INIT;
		endcase
	end

endmodule
